// File: src/wpet_pkg.sv
// Shared types, constants and helpers for the windowed periodic event timer.
package wpet_pkg;

  localparam int EVENT_SLOTS_DEF   = 8;
  localparam int MS_PER_SECOND_DEF = 1000;

  localparam int MS_W      = 8;
  localparam int MIN_W     = 11;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int PERIOD_W  = 16;
  localparam int ACC_W     = 11;
  localparam int ID_W      = 3;
  localparam int REPORT_W  = 2;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 8;

  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_REGISTER = 1'b1;

  localparam logic [REPORT_W-1:0] REPORT_FIRED      = 2'd0;
  localparam logic [REPORT_W-1:0] REPORT_REGISTERED = 2'd1;
  localparam logic [REPORT_W-1:0] REPORT_FULL       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WALK,
    ST_FLUSH
  } wpet_state_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] cdown;
    logic [MIN_W-1:0]    win_end;
    logic [MIN_W-1:0]    win_start;
  } slot_rec_t;

  typedef struct packed {
    logic                active;
    logic [PERIOD_W-1:0] cdown;
    logic                fire;
  } slot_upd_t;

  function automatic logic [MIN_W-1:0] minute_of_day(input logic [HOUR_W-1:0] hour,
                                                     input logic [MINUTE_W-1:0] minute);
    logic [MIN_W-1:0] hh;
    hh = MIN_W'(hour);
    return (hh << 6) - (hh << 2) + MIN_W'(minute);
  endfunction

endpackage

// File: src/windowed_periodic_event_timer.sv
// Windowed periodic event timer: slot table, millisecond accumulator and slot walker.
// Register word: not ready after accept until the result loads the output register.
// Tick word without a new second: the input stays ready. Tick word with a new second:
// the slot walk reads one slot per cycle from the slot memory while the output does
// not stall; the input is not ready during the walk.
// Reset clears the accumulator, slot count, active flags and output valid; slot data is kept.
module windowed_periodic_event_timer #(
  parameter int EVENT_SLOTS   = wpet_pkg::EVENT_SLOTS_DEF,
  parameter int MS_PER_SECOND = wpet_pkg::MS_PER_SECOND_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // ms_passed, current_minute, start_hour, start_minute, end_hour, end_minute,
  // period_seconds, zero pad
  input  logic [wpet_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // event_id, zero pad
  output logic [wpet_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // report
  output logic [wpet_pkg::REPORT_W-1:0]    m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
  localparam logic [wpet_pkg::ACC_W-1:0] MS_LIM = wpet_pkg::ACC_W'(MS_PER_SECOND);

  logic [wpet_pkg::MS_W-1:0]      in_ms;
  logic [wpet_pkg::MIN_W-1:0]     in_now;
  logic [wpet_pkg::HOUR_W-1:0]    in_sh;
  logic [wpet_pkg::MINUTE_W-1:0]  in_sm;
  logic [wpet_pkg::HOUR_W-1:0]    in_eh;
  logic [wpet_pkg::MINUTE_W-1:0]  in_em;
  logic [wpet_pkg::PERIOD_W-1:0]  in_period;

  wpet_pkg::wpet_state_e state_q, state_d;

  logic [wpet_pkg::ACC_W-1:0]     acc_q, acc_d, acc_sum;
  logic [CNT_W-1:0]               used_q, used_d;
  logic [EVENT_SLOTS-1:0]         act_q, act_d;
  logic [wpet_pkg::MIN_W-1:0]     now_q, now_d;
  logic [CNT_W-1:0]               rd_ptr_q, rd_ptr_d;
  logic                           ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]               ev_idx_q, ev_idx_d;
  logic                           pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]               pend_idx_q, pend_idx_d;
  logic [wpet_pkg::ID_W-1:0]      rsp_id_q, rsp_id_d;
  logic [wpet_pkg::REPORT_W-1:0]  rsp_rep_q, rsp_rep_d;
  logic                           out_vld_q, out_vld_d;
  logic [wpet_pkg::ID_W-1:0]      out_id_q, out_id_d;
  logic [wpet_pkg::REPORT_W-1:0]  out_rep_q, out_rep_d;
  logic                           out_last_q, out_last_d;

  wpet_pkg::slot_rec_t            mem_q [EVENT_SLOTS];
  wpet_pkg::slot_rec_t            rec_rd_q;
  wpet_pkg::slot_rec_t            mem_wd;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_wa;
  logic                           rd_en;

  wpet_pkg::slot_upd_t            upd;

  logic s_acc, out_free, full, rd_more, second, stall, advance;

  assign in_ms     = s_axis_tdata[7:0];
  assign in_now    = s_axis_tdata[18:8];
  assign in_sh     = s_axis_tdata[23:19];
  assign in_sm     = s_axis_tdata[29:24];
  assign in_eh     = s_axis_tdata[34:30];
  assign in_em     = s_axis_tdata[40:35];
  assign in_period = s_axis_tdata[56:41];

  assign s_axis_tready = (state_q == wpet_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign full          = (used_q == CNT_W'(EVENT_SLOTS));
  assign rd_more       = (rd_ptr_q < used_q);
  assign acc_sum       = acc_q + wpet_pkg::ACC_W'(in_ms);
  assign second        = (acc_sum >= MS_LIM);
  assign stall         = ev_vld_q && upd.fire && pend_vld_q && !out_free;
  assign advance       = (state_q == wpet_pkg::ST_WALK) && !stall;

  wpet_slot_unit u_slot (
    .rec_i    (rec_rd_q),
    .active_i (act_q[ev_idx_q]),
    .now_i    (now_q),
    .upd_o    (upd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      wpet_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == wpet_pkg::KIND_REGISTER) begin
            state_d = wpet_pkg::ST_EMIT;
          end else if (second) begin
            state_d = wpet_pkg::ST_WALK;
          end
        end
      end
      wpet_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = wpet_pkg::ST_IDLE;
        end
      end
      wpet_pkg::ST_WALK: begin
        if (advance && !ev_vld_q && !rd_more) begin
          state_d = wpet_pkg::ST_FLUSH;
        end
      end
      wpet_pkg::ST_FLUSH: begin
        if (!pend_vld_q || out_free) begin
          state_d = wpet_pkg::ST_IDLE;
        end
      end
      default: state_d = wpet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    acc_d      = acc_q;
    used_d     = used_q;
    act_d      = act_q;
    now_d      = now_q;
    rd_ptr_d   = rd_ptr_q;
    ev_vld_d   = ev_vld_q;
    ev_idx_d   = ev_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    rsp_id_d   = rsp_id_q;
    rsp_rep_d  = rsp_rep_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_id_d   = out_id_q;
    out_rep_d  = out_rep_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_wa     = ev_idx_q;
    mem_wd     = rec_rd_q;
    rd_en      = 1'b0;
    case (state_q)
      wpet_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == wpet_pkg::KIND_REGISTER) begin
            if (!full) begin
              mem_we           = 1'b1;
              mem_wa           = used_q[IDX_W-1:0];
              mem_wd.period    = in_period;
              mem_wd.cdown     = '0;
              mem_wd.win_start = wpet_pkg::minute_of_day(in_sh, in_sm);
              mem_wd.win_end   = wpet_pkg::minute_of_day(in_eh, in_em);
              act_d[used_q[IDX_W-1:0]] = 1'b0;
              used_d    = CNT_W'(used_q + 1'b1);
              rsp_id_d  = wpet_pkg::ID_W'(used_q);
              rsp_rep_d = wpet_pkg::REPORT_REGISTERED;
            end else begin
              rsp_id_d  = '0;
              rsp_rep_d = wpet_pkg::REPORT_FULL;
            end
          end else begin
            acc_d      = second ? (acc_sum - MS_LIM) : acc_sum;
            now_d      = in_now;
            rd_ptr_d   = '0;
            ev_vld_d   = 1'b0;
            pend_vld_d = 1'b0;
          end
        end
      end
      wpet_pkg::ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_id_d   = rsp_id_q;
          out_rep_d  = rsp_rep_q;
          out_last_d = 1'b1;
        end
      end
      wpet_pkg::ST_WALK: begin
        if (advance) begin
          if (ev_vld_q) begin
            mem_we          = 1'b1;
            mem_wd.cdown    = upd.cdown;
            act_d[ev_idx_q] = upd.active;
            if (upd.fire) begin
              if (pend_vld_q) begin
                out_vld_d  = 1'b1;
                out_id_d   = wpet_pkg::ID_W'(pend_idx_q);
                out_rep_d  = wpet_pkg::REPORT_FIRED;
                out_last_d = 1'b0;
              end
              pend_vld_d = 1'b1;
              pend_idx_d = ev_idx_q;
            end
          end
          if (rd_more) begin
            rd_en    = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = rd_ptr_q[IDX_W-1:0];
            rd_ptr_d = CNT_W'(rd_ptr_q + 1'b1);
          end else begin
            ev_vld_d = 1'b0;
          end
        end
      end
      wpet_pkg::ST_FLUSH: begin
        if (pend_vld_q && out_free) begin
          out_vld_d  = 1'b1;
          out_id_d   = wpet_pkg::ID_W'(pend_idx_q);
          out_rep_d  = wpet_pkg::REPORT_FIRED;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        out_vld_d = out_vld_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wpet_pkg::ST_IDLE;
      acc_q      <= '0;
      used_q     <= '0;
      act_q      <= '0;
      rd_ptr_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      used_q     <= used_d;
      act_q      <= act_d;
      rd_ptr_q   <= rd_ptr_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    rsp_id_q   <= rsp_id_d;
    rsp_rep_q  <= rsp_rep_d;
    out_id_q   <= out_id_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rec_rd_q <= mem_q[rd_ptr_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(wpet_pkg::M_TDATA_W - wpet_pkg::ID_W){1'b0}}, out_id_q};
  assign m_axis_tuser  = out_rep_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: src/wpet_slot_unit.sv
// Per-slot update unit, shared by every slot of the one-second walk.
module wpet_slot_unit (
  input  wpet_pkg::slot_rec_t          rec_i,
  input  logic                         active_i,
  input  logic [wpet_pkg::MIN_W-1:0]   now_i,
  output wpet_pkg::slot_upd_t          upd_o
);

  logic                            in_win;
  logic [wpet_pkg::PERIOD_W-1:0]   dec;

  assign in_win = (rec_i.win_start <= now_i) && (now_i <= rec_i.win_end);
  assign dec    = rec_i.cdown - 1'b1;

  always_comb begin
    upd_o.active = active_i;
    upd_o.cdown  = rec_i.cdown;
    upd_o.fire   = 1'b0;
    if (!active_i) begin
      if (in_win) begin
        upd_o.active = 1'b1;
        upd_o.cdown  = wpet_pkg::PERIOD_W'(1);
      end
    end else if (!in_win) begin
      upd_o.active = 1'b0;
      upd_o.cdown  = rec_i.period;
    end else if (dec == '0) begin
      upd_o.cdown = rec_i.period;
      upd_o.fire  = 1'b1;
    end else begin
      upd_o.cdown = dec;
    end
  end

endmodule

// File: src/wpet_checker.sv
// Port-level checks for the windowed periodic event timer, bound to the top level.
module wpet_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wpet_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic [wpet_pkg::REPORT_W-1:0]    m_axis_tuser,
  input logic                             m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_reg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == wpet_pkg::REPORT_REGISTERED
      || m_axis_tuser == wpet_pkg::REPORT_FULL) |-> m_axis_tlast)
    else $error("register answer without tlast");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while a walk still has results");

  a_reg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == wpet_pkg::KIND_REGISTER)
      |=> !s_axis_tready)
    else $error("input ready before register answer was queued");

endmodule

bind windowed_periodic_event_timer wpet_checker u_wpet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
